/* rtl/kas_pkg.sv */
`timescale 1ns / 1ps

package kas_pkg;

    localparam int ANIM_COUNT     = 64;
    localparam int AHEAD_LIMIT_MS = 200;
    localparam int LERP_ONE       = 65536;

    // shared divider geometry
    localparam int DIV_NW = 41;
    localparam int DIV_DW = 33;
    localparam int DIV_CW = $clog2(DIV_NW + 1);

    localparam logic REG_ANIM_ENABLE = 1'b0;

    typedef struct packed {
        logic        func;
        logic [30:0] now_ms;
        logic [7:0]  anim_request;
        logic [15:0] speed_scale;
        logic [15:0] first_frame;
        logic [11:0] frame_count;
        logic [11:0] loop_frames;
        logic [15:0] frame_period_ms;
        logic [15:0] initial_period_ms;
        logic        reversed;
        logic        flip_flop;
    } t_in_item;

    typedef struct packed {
        logic [15:0] frame;
        logic [15:0] old_frame;
        logic [16:0] back_lerp;
        logic        bad_anim;
    } t_out_item;

    typedef enum logic [3:0] {
        CMD_NONE,
        CMD_LOAD,
        CMD_SWITCH,
        CMD_ADV,
        CMD_DIVF,
        CMD_MUL,
        CMD_SCALE,
        CMD_MOD,
        CMD_MODFIX,
        CMD_FRAME,
        CMD_FIN,
        CMD_DIVL,
        CMD_LERP,
        CMD_PUSH
    } t_cmd;

    typedef struct packed {
        logic tick_done;
        logic adv;
        logic zero_period;
        logic need_mod;
        logic den_pos;
        logic div_done;
        logic out_free;
    } t_status;

endpackage

/* rtl/kas_div.sv */
`timescale 1ns / 1ps

module kas_div
    import kas_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [DIV_NW-1:0] i_num,
    input  logic [DIV_DW-1:0] i_den,
    output logic [DIV_NW-1:0] o_quo,
    output logic [DIV_DW-1:0] o_rem,
    output logic              o_done
);

    logic [DIV_NW-1:0] r_quo;
    logic [DIV_DW-1:0] r_rem;
    logic [DIV_DW-1:0] r_den;
    logic [DIV_CW-1:0] r_cnt;
    logic              r_busy;
    logic              r_done;

    logic [DIV_DW:0]   trial;
    logic [DIV_DW:0]   diff;
    logic              take;

    // one quotient bit per cycle, restoring
    always_comb begin
        trial = {r_rem, r_quo[DIV_NW-1]};
        diff  = trial - {1'b0, r_den};
        take  = (trial >= {1'b0, r_den});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == DIV_CW'(DIV_NW - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_num;
            r_rem <= '0;
            r_den <= i_den;
        end else if (r_busy) begin
            r_quo <= {r_quo[DIV_NW-2:0], take};
            r_rem <= take ? diff[DIV_DW-1:0] : trial[DIV_DW-1:0];
        end
    end

    assign o_quo  = r_quo;
    assign o_rem  = r_rem;
    assign o_done = r_done;

endmodule

/* rtl/kas_datapath.sv */
`timescale 1ns / 1ps

module kas_datapath
    import kas_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_cmd      i_cmd,
    input  t_in_item  i_in_data,
    input  logic      i_enable,
    input  logic      i_out_stall,
    output t_status   o_status,
    output logic      o_out_valid,
    output t_out_item o_out_data
);

    t_in_item    r_in;
    logic [7:0]  r_cur_anim;
    logic        r_anim_valid;
    logic [15:0] r_l_first;
    logic [11:0] r_l_count;
    logic [11:0] r_l_loop;
    logic [15:0] r_l_period;
    logic        r_l_rev;
    logic        r_l_flip;
    logic [31:0] r_start;
    logic [31:0] r_next;
    logic [31:0] r_prev;
    logic [15:0] r_frame;
    logic [15:0] r_old;
    logic [16:0] r_lerp;
    logic        r_bad;
    logic        r_dneg;
    logic [32:0] r_dmag;
    logic [48:0] r_prod;
    logic signed [41:0] r_f;
    logic [40:0] r_g;
    logic        r_hold;
    logic [7:0]  r_num;
    logic [32:0] r_den;
    t_out_item   r_out;
    logic        r_out_valid;

    logic [DIV_NW-1:0] div_num;
    logic [DIV_DW-1:0] div_den;
    logic [DIV_NW-1:0] div_quo;
    logic [DIV_DW-1:0] div_rem;
    logic              div_start;
    logic              div_done;

    logic [31:0] now32;
    logic        do_sw;
    logic        sw_bad;
    logic        sw_ok;
    logic [31:0] sw_start;
    logic [31:0] adv_next;
    logic [33:0] adv_d;
    logic [33:0] adv_dneg;
    logic signed [41:0] sc_f;
    logic signed [41:0] sc_nf;
    logic signed [41:0] sc_diff;
    logic        sc_ge;
    logic        sc_need_mod;
    logic signed [41:0] fx_f;
    logic signed [41:0] fr_cnt;
    logic signed [41:0] fr_val;
    logic [32:0] fin_lim;
    logic [31:0] fin_next;
    logic [31:0] fin_prev;
    logic [33:0] fin_den;
    logic        fin_den_pos;
    logic [31:0] fin_num;
    logic        out_free;

    kas_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (div_num),
        .i_den   (div_den),
        .o_quo   (div_quo),
        .o_rem   (div_rem),
        .o_done  (div_done)
    );

    always_comb begin
        now32    = {1'b0, r_in.now_ms};
        sw_bad   = ({1'b0, r_in.anim_request[6:0]} >= 8'(ANIM_COUNT));
        do_sw    = r_in.func
                   || (i_enable && ((r_in.anim_request != r_cur_anim) || !r_anim_valid));
        sw_ok    = do_sw && !sw_bad;
        sw_start = (r_in.func ? now32 : r_next) + {16'b0, r_in.initial_period_ms};

        adv_next = (now32 < r_start) ? r_start : (r_next + {16'b0, r_l_period});
        adv_d    = {2'b0, adv_next} - {2'b0, r_start};
        adv_dneg = -adv_d;

        sc_f     = r_dneg ? -$signed({1'b0, r_prod[48:8]}) : $signed({1'b0, r_prod[48:8]});
        sc_nf    = r_l_flip ? $signed({29'b0, r_l_count, 1'b0})
                            : $signed({30'b0, r_l_count});
        sc_ge    = (sc_f >= sc_nf);
        sc_diff  = sc_f - sc_nf;
        sc_need_mod = sc_ge && (r_l_loop != '0);

        fx_f     = $signed({30'b0, div_rem[11:0]}) + $signed({30'b0, r_l_count})
                   - $signed({30'b0, r_l_loop});

        fr_cnt   = $signed({30'b0, r_l_count});
        if (r_l_rev) begin
            fr_val = $signed({26'b0, r_l_first}) + fr_cnt - 42'sd1 - r_f;
        end else if (r_l_flip && (r_f >= fr_cnt) && (r_l_count != '0)) begin
            fr_val = $signed({26'b0, r_l_first}) + fr_cnt - 42'sd1 - (r_f - fr_cnt);
        end else begin
            fr_val = $signed({26'b0, r_l_first}) + r_f;
        end

        fin_lim  = {1'b0, now32} + 33'(AHEAD_LIMIT_MS);
        fin_next = ({1'b0, r_next} > fin_lim) ? now32 : r_next;
        fin_prev = (r_prev > now32) ? now32 : r_prev;
        fin_den  = {2'b0, fin_next} - {2'b0, fin_prev};
        fin_den_pos = !fin_den[33] && (fin_den != '0);
        fin_num  = (fin_next > now32) ? (fin_next - now32) : '0;

        out_free = !r_out_valid || !i_out_stall;

        div_start = (i_cmd == CMD_DIVF) || (i_cmd == CMD_MOD) || (i_cmd == CMD_DIVL);
        unique case (i_cmd)
            CMD_DIVF: begin
                div_num = {8'b0, r_dmag};
                div_den = {17'b0, r_l_period};
            end
            CMD_MOD: begin
                div_num = r_g;
                div_den = {21'b0, r_l_loop};
            end
            default: begin
                div_num = {17'b0, r_num, 16'b0};
                div_den = r_den;
            end
        endcase
    end

    always_comb begin
        o_status.tick_done   = r_in.func || !i_enable;
        o_status.adv         = (now32 >= r_next);
        o_status.zero_period = (r_l_period == '0);
        o_status.need_mod    = sc_need_mod;
        o_status.den_pos     = fin_den_pos;
        o_status.div_done    = div_done;
        o_status.out_free    = out_free;
    end

    // animation state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur_anim   <= '0;
            r_anim_valid <= 1'b0;
            r_l_first    <= '0;
            r_l_count    <= '0;
            r_l_loop     <= '0;
            r_l_period   <= '0;
            r_l_rev      <= 1'b0;
            r_l_flip     <= 1'b0;
            r_start      <= '0;
            r_next       <= '0;
            r_prev       <= '0;
            r_frame      <= '0;
            r_old        <= '0;
            r_lerp       <= '0;
            r_bad        <= 1'b0;
        end else begin
            case (i_cmd)
                CMD_SWITCH: begin
                    r_bad <= do_sw && sw_bad;
                    if (sw_ok) begin
                        r_cur_anim   <= r_in.anim_request;
                        r_anim_valid <= 1'b1;
                        r_l_first    <= r_in.first_frame;
                        r_l_count    <= r_in.frame_count;
                        r_l_loop     <= r_in.loop_frames;
                        r_l_period   <= r_in.frame_period_ms;
                        r_l_rev      <= r_in.reversed;
                        r_l_flip     <= r_in.flip_flop;
                        r_start      <= sw_start;
                    end
                    if (r_in.func) begin
                        r_next  <= now32;
                        r_prev  <= now32;
                        r_frame <= sw_ok ? r_in.first_frame : r_l_first;
                        r_old   <= sw_ok ? r_in.first_frame : r_l_first;
                    end else if (!i_enable) begin
                        r_frame <= '0;
                        r_old   <= '0;
                        r_lerp  <= '0;
                    end
                end
                CMD_ADV: begin
                    r_old  <= r_frame;
                    r_prev <= r_next;
                    if (r_l_period != '0) begin
                        r_next <= adv_next;
                    end
                end
                CMD_FRAME: begin
                    r_frame <= fr_val[15:0];
                    if (r_hold || (now32 > r_next)) begin
                        r_next <= now32;
                    end
                end
                CMD_FIN: begin
                    r_next <= fin_next;
                    r_prev <= fin_prev;
                    if (!fin_den_pos) begin
                        r_lerp <= '0;
                    end
                end
                CMD_LERP: begin
                    r_lerp <= (div_quo > DIV_NW'(LERP_ONE)) ? 17'(LERP_ONE) : div_quo[16:0];
                end
                default: begin
                end
            endcase
        end
    end

    // scratch registers of the tick arithmetic
    always_ff @(posedge i_clk) begin
        case (i_cmd)
            CMD_LOAD: r_in <= i_in_data;
            CMD_ADV: begin
                r_dneg <= adv_d[33];
                r_dmag <= adv_d[33] ? adv_dneg[32:0] : adv_d[32:0];
            end
            CMD_MUL: r_prod <= 49'(div_quo[32:0]) * 49'(r_in.speed_scale);
            CMD_SCALE: begin
                r_g    <= sc_diff[40:0];
                r_hold <= sc_ge && (r_l_loop == '0);
                if (sc_ge && (r_l_loop == '0)) begin
                    r_f <= sc_nf - 42'sd1;
                end else begin
                    r_f <= sc_f;
                end
            end
            CMD_MODFIX: r_f <= fx_f;
            CMD_FIN: begin
                r_den <= fin_den[32:0];
                r_num <= fin_num[7:0];
            end
            default: begin
            end
        endcase
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd == CMD_PUSH) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd == CMD_PUSH) begin
            r_out.frame     <= i_enable ? r_frame : '0;
            r_out.old_frame <= i_enable ? r_old : '0;
            r_out.back_lerp <= i_enable ? r_lerp : '0;
            r_out.bad_anim  <= r_bad;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

/* rtl/kas_ctrl.sv */
`timescale 1ns / 1ps

module kas_ctrl
    import kas_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    input  t_status i_status,
    output t_cmd    o_cmd,
    output logic    o_idle
);

    typedef enum logic [16:0] {
        S_IDLE   = 17'b00000000000000001,
        S_SWITCH = 17'b00000000000000010,
        S_ADV    = 17'b00000000000000100,
        S_DIVF   = 17'b00000000000001000,
        S_WAITF  = 17'b00000000000010000,
        S_MUL    = 17'b00000000000100000,
        S_SCALE  = 17'b00000000001000000,
        S_MOD    = 17'b00000000010000000,
        S_WAITM  = 17'b00000000100000000,
        S_MODFIX = 17'b00000001000000000,
        S_FRAME  = 17'b00000010000000000,
        S_FIN    = 17'b00000100000000000,
        S_DIVL   = 17'b00001000000000000,
        S_WAITL  = 17'b00010000000000000,
        S_LERP   = 17'b00100000000000000,
        S_DONE   = 17'b01000000000000000,
        S_SPARE  = 17'b10000000000000000
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = CMD_NONE;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd   = CMD_LOAD;
                    n_state = S_SWITCH;
                end
            end
            S_SWITCH: begin
                o_cmd = CMD_SWITCH;
                if (i_status.tick_done) begin
                    n_state = S_DONE;
                end else if (i_status.adv) begin
                    n_state = S_ADV;
                end else begin
                    n_state = S_FIN;
                end
            end
            S_ADV: begin
                o_cmd   = CMD_ADV;
                n_state = i_status.zero_period ? S_DONE : S_DIVF;
            end
            S_DIVF: begin
                o_cmd   = CMD_DIVF;
                n_state = S_WAITF;
            end
            S_WAITF: begin
                if (i_status.div_done) begin
                    n_state = S_MUL;
                end
            end
            S_MUL: begin
                o_cmd   = CMD_MUL;
                n_state = S_SCALE;
            end
            S_SCALE: begin
                o_cmd   = CMD_SCALE;
                n_state = i_status.need_mod ? S_MOD : S_FRAME;
            end
            S_MOD: begin
                o_cmd   = CMD_MOD;
                n_state = S_WAITM;
            end
            S_WAITM: begin
                if (i_status.div_done) begin
                    n_state = S_MODFIX;
                end
            end
            S_MODFIX: begin
                o_cmd   = CMD_MODFIX;
                n_state = S_FRAME;
            end
            S_FRAME: begin
                o_cmd   = CMD_FRAME;
                n_state = S_FIN;
            end
            S_FIN: begin
                o_cmd   = CMD_FIN;
                n_state = i_status.den_pos ? S_DIVL : S_DONE;
            end
            S_DIVL: begin
                o_cmd   = CMD_DIVL;
                n_state = S_WAITL;
            end
            S_WAITL: begin
                if (i_status.div_done) begin
                    n_state = S_LERP;
                end
            end
            S_LERP: begin
                o_cmd   = CMD_LERP;
                n_state = S_DONE;
            end
            S_DONE: begin
                if (i_status.out_free) begin
                    o_cmd   = CMD_PUSH;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_idle = (r_state == S_IDLE);

    a_push_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd == CMD_PUSH) |-> i_status.out_free)
        else $error("result pushed while output register busy");

    a_wait_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WAITF && !i_status.div_done) |=> (r_state == S_WAITF))
        else $error("left divide wait early");

    a_accept_go: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE && i_in_valid) |=> (r_state == S_SWITCH))
        else $error("accepted item not processed");

endmodule

/* rtl/keyframe_animation_sequencer.sv */
`timescale 1ns / 1ps

// Channel   | Direction | Handshake                   | Payload
// ----------+-----------+-----------------------------+--------------------------
// input     | in        | i_in_valid / o_in_stall     | i_in_data  (t_in_item)
// result    | out       | o_out_valid / i_out_stall   | o_out_data (t_out_item)
// config    | in        | psel/penable/pwrite/pready  | paddr, pwdata, prdata
//
// An item skips the arithmetic when disabled or clearing; a full advance makes
// three passes of the shared radix-2 divider (frame step, loop modulo, lerp
// fraction). One item is worked at a time.
// Reset is synchronous, active low; animation_enable resets to 1.
// A finished result waits in the output register; the next item is taken meanwhile
// and only its own push waits for the result transfer to clear.

module keyframe_animation_sequencer
    import kas_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  t_in_item    i_in_data,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output t_out_item   o_out_data,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [0:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic    r_enable;
    logic    idle;
    t_cmd    cmd;
    t_status status;
    logic    cfg_wr;

    // Config write completes on the access phase; pready is tied high.
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enable <= 1'b1;
        end else if (cfg_wr && (paddr == REG_ANIM_ENABLE)) begin
            r_enable <= pwdata[0];
        end
    end

    // Read back the enable; any other address reads zero.
    assign prdata = (paddr == REG_ANIM_ENABLE) ? {31'b0, r_enable} : '0;

    // Take a new transfer only while the controller sits idle.
    assign o_in_stall = !idle;

    kas_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_status   (status),
        .o_cmd      (cmd),
        .o_idle     (idle)
    );

    kas_datapath u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_in_data   (i_in_data),
        .i_enable    (r_enable),
        .i_out_stall (i_out_stall),
        .o_status    (status),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data)
    );

endmodule

/* test/frame_advance_checker.sv */
`timescale 1ns / 1ps

module frame_advance_checker
    import kas_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    input  logic        i_in_stall,
    input  t_in_item    i_in_data,
    input  logic        i_out_valid,
    input  logic        i_out_stall,
    input  t_out_item   i_out_data,
    input  logic        i_psel,
    input  logic        i_penable,
    input  logic        i_pwrite,
    input  logic        i_pready,
    input  logic [0:0]  i_paddr,
    input  logic [31:0] i_pwdata,
    output int          o_errors,
    output int          o_pending,
    output int          o_checked
);

    bit        anim_enable;
    bit [7:0]  cur_anim;
    bit        anim_ok;
    bit [15:0] lat_first;
    bit [11:0] lat_count;
    bit [11:0] lat_loop;
    bit [15:0] lat_period;
    bit [1:0]  lat_flags;
    bit [31:0] t_start;
    bit [31:0] t_next;
    bit [31:0] t_prev;
    bit [15:0] frm;
    bit [15:0] ofrm;
    bit [16:0] lerp;

    t_out_item expected_frames[$];

    initial begin
        o_errors  = 0;
        o_pending = 0;
        o_checked = 0;
    end

    // latch the descriptor unless the number is out of range
    function automatic bit switch_anim(t_in_item it);
        if (it.anim_request[6:0] >= ANIM_COUNT) return 1'b1;
        cur_anim   = it.anim_request;
        anim_ok    = 1'b1;
        lat_first  = it.first_frame;
        lat_count  = it.frame_count;
        lat_loop   = it.loop_frames;
        lat_period = it.frame_period_ms;
        lat_flags  = {it.flip_flop, it.reversed};
        t_start    = t_next + 32'(it.initial_period_ms);
        return 1'b0;
    endfunction

    // clamp the frame times and work out the back fraction
    function automatic void settle_lerp(longint now);
        longint den;
        longint num;
        longint q;
        if (longint'(t_next) > now + AHEAD_LIMIT_MS) t_next = now[31:0];
        if (longint'(t_prev) > now) t_prev = now[31:0];
        den = longint'(t_next) - longint'(t_prev);
        if (den <= 0) begin
            lerp = '0;
            return;
        end
        num = longint'(t_next) - now;
        if (num < 0) num = 0;
        q = (num * LERP_ONE) / den;
        if (q > LERP_ONE) q = LERP_ONE;
        lerp = q[16:0];
    endfunction

    function automatic t_out_item predict_frame_step(t_in_item it);
        t_out_item r;
        bit        bad;
        longint    now;
        longint    f;
        longint    nf;
        longint    cnt;
        longint    loop_n;
        longint    fr;
        bad = 1'b0;
        now = longint'(it.now_ms);
        if (it.func) begin
            t_next = now[31:0];
            t_prev = now[31:0];
            bad    = switch_anim(it);
            frm    = lat_first;
            ofrm   = lat_first;
        end else if (!anim_enable) begin
            frm  = '0;
            ofrm = '0;
            lerp = '0;
        end else begin
            if (it.anim_request != cur_anim || !anim_ok) bad = switch_anim(it);
            if (now >= longint'(t_next)) begin
                ofrm   = frm;
                t_prev = t_next;
                if (lat_period != 0) begin
                    if (now < longint'(t_start)) t_next = t_start;
                    else t_next = t_prev + 32'(lat_period);
                    f = (longint'(t_next) - longint'(t_start)) / longint'(lat_period);
                    f = (f * longint'(it.speed_scale)) / 256;
                    cnt    = longint'(lat_count);
                    loop_n = longint'(lat_loop);
                    nf     = lat_flags[1] ? cnt * 2 : cnt;
                    if (f >= nf) begin
                        f = f - nf;
                        if (loop_n != 0) begin
                            f = f % loop_n;
                            f = f + cnt - loop_n;
                        end else begin
                            // hold the last frame
                            f      = nf - 1;
                            t_next = now[31:0];
                        end
                    end
                    if (lat_flags[0])
                        fr = longint'(lat_first) + cnt - 1 - f;
                    else if (lat_flags[1] && f >= cnt && cnt != 0)
                        fr = longint'(lat_first) + cnt - 1 - (f % cnt);
                    else
                        fr = longint'(lat_first) + f;
                    frm = fr[15:0];
                    if (now > longint'(t_next)) t_next = now[31:0];
                    settle_lerp(now);
                end
            end else begin
                settle_lerp(now);
            end
        end
        r.frame     = anim_enable ? frm  : '0;
        r.old_frame = anim_enable ? ofrm : '0;
        r.back_lerp = anim_enable ? lerp : '0;
        r.bad_anim  = bad;
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_out_item exp_r;
        if (!i_rst_n) begin
            anim_enable = 1'b1;
            cur_anim    = '0;
            anim_ok     = 1'b0;
            lat_first   = '0;
            lat_count   = '0;
            lat_loop    = '0;
            lat_period  = '0;
            lat_flags   = '0;
            t_start     = '0;
            t_next      = '0;
            t_prev      = '0;
            frm         = '0;
            ofrm        = '0;
            lerp        = '0;
            expected_frames.delete();
        end else begin
            if (i_out_valid && !i_out_stall) begin
                if (expected_frames.size() == 0) begin
                    $display("%0t: unexpected result transfer %p", $time, i_out_data);
                    o_errors++;
                end else begin
                    exp_r = expected_frames.pop_front();
                    o_checked++;
                    if (i_out_data.frame !== exp_r.frame) begin
                        $display("%0t: frame exp %0d got %0d",
                                 $time, exp_r.frame, i_out_data.frame);
                        o_errors++;
                    end
                    if (i_out_data.old_frame !== exp_r.old_frame) begin
                        $display("%0t: old_frame exp %0d got %0d",
                                 $time, exp_r.old_frame, i_out_data.old_frame);
                        o_errors++;
                    end
                    if (i_out_data.back_lerp !== exp_r.back_lerp) begin
                        $display("%0t: back_lerp exp %0d got %0d",
                                 $time, exp_r.back_lerp, i_out_data.back_lerp);
                        o_errors++;
                    end
                    if (i_out_data.bad_anim !== exp_r.bad_anim) begin
                        $display("%0t: bad_anim exp %0d got %0d",
                                 $time, exp_r.bad_anim, i_out_data.bad_anim);
                        o_errors++;
                    end
                end
            end
            if (i_in_valid && !i_in_stall)
                expected_frames.push_back(predict_frame_step(i_in_data));
            if (i_psel && i_penable && i_pwrite && i_pready && i_paddr == REG_ANIM_ENABLE)
                anim_enable = i_pwdata[0];
        end
        o_pending = expected_frames.size();
    end

endmodule

/* test/tb.sv */
`timescale 1ns / 1ps

module tb;
    import kas_pkg::*;

    localparam int IDLE_LIMIT = 20000;  // cycles with no transfer before giving up
    localparam int DRAIN_CYCLES = 300;  // covers one full advance of the block

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    t_in_item    in_data = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    t_out_item   out_data;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [0:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    int errors;
    int pending;
    int checked;
    int items_sent = 0;
    int idle_pct = 0;   // chance the sender skips a cycle
    int stall_pct = 0;  // chance the receiver stalls a cycle
    bit hold_req = 1'b0;
    int hold_left = 0;
    int idle_run = 0;
    int unsigned sim_ms = 0;

    always #2 i_clk = ~i_clk;

    keyframe_animation_sequencer i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (out_data),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    frame_advance_checker i_chk (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .i_in_stall  (in_stall),
        .i_in_data   (in_data),
        .i_out_valid (out_valid),
        .i_out_stall (out_stall),
        .i_out_data  (out_data),
        .i_psel      (psel),
        .i_penable   (penable),
        .i_pwrite    (pwrite),
        .i_pready    (pready),
        .i_paddr     (paddr),
        .i_pwdata    (pwdata),
        .o_errors    (errors),
        .o_pending   (pending),
        .o_checked   (checked)
    );

    // Receiver: a requested hold is counted out here, otherwise stall at random.
    always @(negedge i_clk) begin
        if (hold_req) begin
            hold_left = 600;
            hold_req  = 1'b0;
        end
        if (hold_left > 0) begin
            out_stall <= 1'b1;
            hold_left--;
        end else begin
            out_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    // Watchdog: end the run when no transfer happens for too long.
    always @(posedge i_clk) begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
            idle_run <= 0;
        end else if (idle_run >= IDLE_LIMIT) begin
            $display("%0t: no transfer for %0d cycles", $time, IDLE_LIMIT);
            $display("RESULT: ERROR");
            $finish;
        end else begin
            idle_run <= idle_run + 1;
        end
    end

    // Offer one item, with random idle cycles ahead of it; return on its transfer.
    task automatic offer_item(t_in_item it);
        int gap;
        gap = 0;
        while (gap < 40 && $urandom_range(99) < idle_pct) gap++;
        if (gap > 0) begin
            @(negedge i_clk);
            in_valid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        in_valid <= 1'b1;
        in_data  <= it;
        do @(posedge i_clk); while (in_stall);
        items_sent++;
    endtask

    task automatic tick(bit func, int unsigned now, bit [7:0] req, bit [15:0] speed,
                        bit [15:0] first, bit [11:0] cnt, bit [11:0] loop_n,
                        bit [15:0] per, bit [15:0] init, bit rev, bit ff);
        t_in_item it;
        it.func              = func;
        it.now_ms            = now[30:0];
        it.anim_request      = req;
        it.speed_scale       = speed;
        it.first_frame       = first;
        it.frame_count       = cnt;
        it.loop_frames       = loop_n;
        it.frame_period_ms   = per;
        it.initial_period_ms = init;
        it.reversed          = rev;
        it.flip_flop         = ff;
        offer_item(it);
    endtask

    // Drop valid, wait for every expected result, then let the block settle.
    task automatic drain;
        @(negedge i_clk);
        in_valid <= 1'b0;
        wait (pending == 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_enable(bit value);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= REG_ANIM_ENABLE;
        pwdata  <= {31'b0, value};
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // One playback: a clear, then ticks with time moving forward and an
    // occasional switch or stray item mixed in.
    task automatic play_session(int n_ticks);
        bit [7:0]  req;
        bit [15:0] first;
        bit [11:0] cnt;
        bit [11:0] loop_n;
        bit [15:0] per;
        bit [15:0] init;
        bit [15:0] speed;
        bit        rev;
        bit        ff;
        t_in_item  junk;
        req    = {1'($urandom), 7'($urandom_range(0, ($urandom_range(9) == 0) ? 127 : 63))};
        first  = 16'($urandom);
        cnt    = ($urandom_range(9) == 0) ? 12'($urandom) : 12'($urandom_range(0, 20));
        loop_n = ($urandom_range(3) == 0) ? 12'd0 : 12'($urandom_range(0, cnt + 2));
        per    = ($urandom_range(9) == 0) ? 16'd0 : 16'($urandom_range(1, 60));
        init   = 16'($urandom_range(0, 150));
        speed  = ($urandom_range(2) == 0) ? 16'd256 : 16'($urandom_range(0, 1024));
        rev    = $urandom_range(3) == 0;
        ff     = $urandom_range(2) == 0;
        sim_ms = $urandom_range(0, 32'h7FFF_0000);
        tick(1'b1, sim_ms, req, speed, first, cnt, loop_n, per, init, rev, ff);
        for (int k = 0; k < n_ticks; k++) begin
            case ($urandom_range(19))
                0: begin
                    junk = t_in_item'({2'($urandom), $urandom, $urandom, $urandom,
                                       $urandom});
                    offer_item(junk);
                end
                1: begin
                    req[7] = ~req[7];
                    tick(1'b0, sim_ms, req, speed, first, cnt, loop_n, per, init, rev, ff);
                end
                default: begin
                    sim_ms = sim_ms + $urandom_range(0, (per == 0) ? 50 : 2 * per + 5);
                    tick(1'b0, sim_ms, req, speed, first, cnt, loop_n, per, init, rev, ff);
                end
            endcase
        end
    endtask

    task automatic random_phase(int n_items);
        int goal;
        goal = items_sent + n_items;
        while (items_sent < goal) play_session($urandom_range(4, 30));
    endtask

    initial begin
        repeat (9) @(negedge i_clk);
        i_rst_n <= 1'b1;
        write_enable(1'b1);

        // Directed: looping, hold at end, reversed, ping-pong, odd descriptors.
        tick(1, 100, 8'd1, 16'd256, 16'd10, 12'd5, 12'd2, 16'd10, 16'd20, 0, 0);
        tick(0, 110, 8'd1, 16'd256, 16'd10, 12'd5, 12'd2, 16'd10, 16'd20, 0, 0);
        tick(0, 135, 8'd1, 16'd256, 16'd10, 12'd5, 12'd2, 16'd10, 16'd20, 0, 0);
        tick(0, 190, 8'd1, 16'd256, 16'd10, 12'd5, 12'd2, 16'd10, 16'd20, 0, 0);
        tick(0, 600, 8'd1, 16'd256, 16'd10, 12'd5, 12'd2, 16'd10, 16'd20, 0, 0);
        tick(1, 700, 8'd2, 16'd256, 16'd50, 12'd3, 12'd0, 16'd10, 16'd0, 0, 0);
        tick(0, 750, 8'd2, 16'd256, 16'd50, 12'd3, 12'd0, 16'd10, 16'd0, 0, 0);
        tick(0, 900, 8'd2, 16'd256, 16'd50, 12'd3, 12'd0, 16'd10, 16'd0, 0, 0);
        tick(0, 920, 8'd3, 16'd512, 16'd0, 12'd6, 12'd6, 16'd5, 16'd0, 1, 0);
        tick(0, 960, 8'd3, 16'd512, 16'd0, 12'd6, 12'd6, 16'd5, 16'd0, 1, 0);
        tick(0, 970, 8'd4, 16'd256, 16'd30, 12'd4, 12'd8, 16'd4, 16'd0, 0, 1);
        tick(0, 1000, 8'd4, 16'd256, 16'd30, 12'd4, 12'd8, 16'd4, 16'd0, 0, 1);
        tick(0, 1010, 8'd5, 16'd256, 16'd7, 12'd0, 12'd0, 16'd3, 16'd0, 0, 1);
        tick(0, 1030, 8'd5, 16'd256, 16'd7, 12'd0, 12'd0, 16'd3, 16'd0, 0, 1);
        tick(0, 1040, 8'd6, 16'd256, 16'd9, 12'd4, 12'd2, 16'd0, 16'd5, 0, 0);
        tick(0, 1080, 8'd6, 16'd256, 16'd9, 12'd4, 12'd2, 16'd0, 16'd5, 0, 0);
        tick(0, 1100, 8'd64, 16'd0, 16'd1, 12'd2, 12'd1, 16'd2, 16'd0, 0, 0);
        tick(1, 1150, 8'hFF, 16'd0, 16'd1, 12'd2, 12'd1, 16'd2, 16'd0, 0, 0);
        tick(0, 1200, 8'h86, 16'hFFFF, 16'd9, 12'd4, 12'd2, 16'd1, 16'd0, 0, 0);
        tick(0, 1400, 8'h86, 16'hFFFF, 16'd9, 12'd4, 12'd2, 16'd1, 16'd0, 0, 0);
        tick(1, 32'h7FFF_FFFF, 8'h3F, 16'hFFFF, 16'hFFFF, 12'hFFF, 12'hFFF, 16'hFFFF,
             16'hFFFF, 1, 1);
        tick(0, 32'h7FFF_FFFF, 8'h3F, 16'hFFFF, 16'hFFFF, 12'hFFF, 12'hFFF, 16'hFFFF,
             16'hFFFF, 1, 1);
        tick(0, 0, 8'h00, 16'd0, 16'd0, 12'd0, 12'd0, 16'd0, 16'd0, 0, 0);
        drain();

        // Disabled: outputs forced to zero, clears still latch.
        write_enable(1'b0);
        stall_pct = 16;
        idle_pct  = 16;
        random_phase(60);
        drain();
        write_enable(1'b1);

        // Full rate, with a long receiver hold while items keep coming.
        stall_pct = 0;
        idle_pct  = 0;
        hold_req  = 1'b1;
        random_phase(140);
        drain();

        idle_pct = 80;
        random_phase(140);
        drain();

        idle_pct  = 0;
        stall_pct = 80;
        random_phase(140);
        drain();

        idle_pct  = 16;
        stall_pct = 16;
        random_phase(140);
        drain();

        $display("Sent %0d items (directed, looping/hold/reverse/ping-pong playback, noise),",
                 items_sent);
        $display("checked %0d results across enable off/on and four flow-control mixes.",
                 checked);
        if (errors == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
